// ===== rtl/core/form_urlencoded_splitter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// form_urlencoded_splitter_unit_defines
// assertion macros shared by the splitter rtl
// ----------------------------------------------------------------------------
`ifndef FORM_URLENCODED_SPLITTER_UNIT_DEFINES_SVH
`define FORM_URLENCODED_SPLITTER_UNIT_DEFINES_SVH

// plain property that must hold at every edge outside reset
`define FUS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// same-cycle implication
`define FUS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// next-cycle implication
`define FUS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/core/fus_pkg.sv =====
// ----------------------------------------------------------------------------
// fus_pkg
// types, character codes and digit decode for the form splitter
// ----------------------------------------------------------------------------
package fus_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3d;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CASE_MASK    = 8'hdf;
   localparam logic [7:0] ALPHA_BASE   = 8'd10;

   localparam logic [15:0] COUNT_MAX   = 16'hffff;

   // response queue entries, a power of two so the pointers wrap by themselves
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_NAME     = 2'd0,
      KIND_VALUE    = 2'd1,
      KIND_PAIR_END = 2'd2,
      KIND_STR_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    kind;
      logic [15:0] pair_number;
      logic        bad_escape;
      logic        last;
   } rsp_type;

   // unchecked hex digit decode, 8-bit wrap
   function automatic logic [7:0] digit_value(input logic [7:0] d);
      logic [7:0] v;
      if (d >= CHAR_UPPER_A) begin
         v = (d & CASE_MASK) - CHAR_UPPER_A + ALPHA_BASE;
      end else begin
         v = d - CHAR_ZERO;
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/form_urlencoded_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// form_urlencoded_splitter_unit
// splits a form-urlencoded argument string into name/value bytes and pair ends
// ----------------------------------------------------------------------------
// Usage: the req channel takes one string byte per request, with req_tlast on
// the final byte of the string. The rsp channel gives name bytes, value bytes
// (percent-unescaped, '+' as space), a pair-end marker per non-empty pair and,
// when no pair is open at the string end, a string-end marker. rsp_tlast is
// set on the last response of a string.
// Each request is decoded in the cycle it is accepted and its zero, one or two
// responses are written into a four-entry response queue; rsp is driven from
// the registered queue, not from the byte. One request is taken every cycle
// while the queue holds at most two entries, so the rate is one byte per
// cycle, bounded by the single response per cycle the queue drains when a
// byte yields two responses (string end closing a pair).
// Reset clears the parse state, pair counter and the queue, with no
// initialization sequence after it. When the receiver stalls, the queue fills and
// req_tready drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
`include "form_urlencoded_splitter_unit_defines.svh"

module form_urlencoded_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [23:8] pair_number,
                                    // [24] bad_escape, [31:25] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);
   import fus_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] FreeLimit = CntW'(QUEUE_DEPTH - 2);
   localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

   // parse state
   logic          value_part_ff, value_part_in;
   esc_type       esc_ff, esc_in;
   logic [3:0]    high_nib_ff, high_nib_in;
   logic          pair_open_ff, pair_open_in;
   logic [15:0]   pair_count_ff, pair_count_in;

   // response queue
   rsp_type             queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   logic        req_accept;
   logic        rsp_accept;
   logic [7:0]  b;
   logic [7:0]  dig;
   logic        a_valid;
   rsp_type     a_rsp;
   logic        e_valid;
   rsp_type     e_rsp;
   logic [PtrW-1:0] e_ptr;
   logic [1:0]  push_n;
   rsp_type     head;

   // state after the byte itself, before the string-end step
   logic        mid_value_part;
   esc_type     mid_esc;
   logic [3:0]  mid_high_nib;
   logic        mid_pair_open;
   logic [15:0] mid_pair_count;

   assign req_tready = (count_ff <= FreeLimit);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   assign b   = (req_tdata == CHAR_PLUS) ? CHAR_SPACE : req_tdata;
   assign dig = digit_value(b);

   always_comb begin
      mid_value_part = value_part_ff;
      mid_esc        = esc_ff;
      mid_high_nib   = high_nib_ff;
      mid_pair_open  = pair_open_ff;
      mid_pair_count = pair_count_ff;
      a_valid        = 1'b0;
      a_rsp          = '{out_byte: 8'd0, kind: KIND_NAME, pair_number: pair_count_ff,
                         bad_escape: 1'b0, last: 1'b0};
      if (b == CHAR_AMP) begin
         if (pair_open_ff) begin
            a_valid          = 1'b1;
            a_rsp.kind       = KIND_PAIR_END;
            a_rsp.bad_escape = (esc_ff != ESC_NONE);
            mid_value_part   = 1'b0;
            mid_esc          = ESC_NONE;
            mid_high_nib     = 4'd0;
            mid_pair_open    = 1'b0;
            if (pair_count_ff != COUNT_MAX) begin
               mid_pair_count = pair_count_ff + 16'd1;
            end
         end
      end else begin
         mid_pair_open = 1'b1;
         if (!value_part_ff) begin
            if (b == CHAR_EQUAL) begin
               mid_value_part = 1'b1;
            end else begin
               a_valid        = 1'b1;
               a_rsp.out_byte = b;
            end
         end else if (esc_ff == ESC_HIGH) begin
            mid_high_nib = dig[3:0];
            mid_esc      = ESC_LOW;
         end else if (esc_ff == ESC_LOW) begin
            mid_esc        = ESC_NONE;
            mid_high_nib   = 4'd0;
            a_valid        = 1'b1;
            a_rsp.kind     = KIND_VALUE;
            a_rsp.out_byte = {high_nib_ff, 4'd0} + dig;
         end else if (b == CHAR_PERCENT) begin
            mid_esc = ESC_HIGH;
         end else begin
            a_valid        = 1'b1;
            a_rsp.kind     = KIND_VALUE;
            a_rsp.out_byte = b;
         end
      end
   end

   // string end: close the open pair or report the pair total
   always_comb begin
      e_valid = req_tlast;
      e_rsp   = '{out_byte: 8'd0, kind: KIND_STR_END, pair_number: mid_pair_count,
                  bad_escape: 1'b0, last: 1'b1};
      if (mid_pair_open) begin
         e_rsp.kind       = KIND_PAIR_END;
         e_rsp.bad_escape = (mid_esc != ESC_NONE);
      end
   end

   always_comb begin
      value_part_in = value_part_ff;
      esc_in        = esc_ff;
      high_nib_in   = high_nib_ff;
      pair_open_in  = pair_open_ff;
      pair_count_in = pair_count_ff;
      if (req_accept) begin
         if (req_tlast) begin
            value_part_in = 1'b0;
            esc_in        = ESC_NONE;
            high_nib_in   = 4'd0;
            pair_open_in  = 1'b0;
            pair_count_in = 16'd0;
         end else begin
            value_part_in = mid_value_part;
            esc_in        = mid_esc;
            high_nib_in   = mid_high_nib;
            pair_open_in  = mid_pair_open;
            pair_count_in = mid_pair_count;
         end
      end
   end

   assign push_n    = req_accept ? ({1'b0, a_valid} + {1'b0, e_valid}) : 2'd0;
   assign e_ptr     = wr_ptr_ff + PtrW'(a_valid);
   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(rsp_accept);
   assign count_in  = count_ff + CntW'(push_n) - CntW'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         value_part_ff <= 1'b0;
         esc_ff        <= ESC_NONE;
         high_nib_ff   <= 4'd0;
         pair_open_ff  <= 1'b0;
         pair_count_ff <= 16'd0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         value_part_ff <= value_part_in;
         esc_ff        <= esc_in;
         high_nib_ff   <= high_nib_in;
         pair_open_ff  <= pair_open_in;
         pair_count_ff <= pair_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && a_valid) begin
         queue_ff[wr_ptr_ff] <= a_rsp;
      end
      if (req_accept && e_valid) begin
         queue_ff[e_ptr] <= e_rsp;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {7'd0, head.bad_escape, head.pair_number, head.out_byte};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   `FUS_ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= FullCount)
   `FUS_ASSERT_IMPL(a_escape_in_value, clock, reset, esc_ff != ESC_NONE, value_part_ff)
   `FUS_ASSERT_NEXT(a_end_clears, clock, reset, req_accept && req_tlast,
      pair_count_ff == 16'd0 && !pair_open_ff && !value_part_ff)
   `FUS_ASSERT_IMPL(a_data_flags, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_NAME || rsp_tuser == KIND_VALUE),
      !rsp_tdata[24] && !rsp_tlast)

endmodule
